// File: src/cal_pkg.sv
`timescale 1ns / 1ps

package cal_pkg;

    localparam int DEPTH  = 64;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_PREPEND = 2'd1;
    localparam logic [1:0] CMD_APPEND  = 2'd2;
    localparam logic [1:0] CMD_REMOVE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // one store request per cycle, a write and a read: logical indexes, mapped through the head pointer
    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_idx;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_idx;
    } mem_req_t;

endpackage

// File: src/circular_array_list.sv
`timescale 1ns / 1ps

// List of up to DEPTH 32-bit elements in a circular store with a head pointer
// and a count. Each item is one command (get, prepend, append, remove at
// index) and gives exactly one result with read data, status and the new
// count. The block takes one item at a time, from S_DECIDE to S_RESP: a get
// that succeeds passes through S_GET for the read data, a removal that moves
// elements through S_SHIFT. That removal moves n elements by one slot: those
// before the index if it is at most half the count, else those after it, so
// n is at most DEPTH/2. The single store port pair does one read and one
// write per cycle while the shift walks the elements. A new item is
// accepted while the previous result still waits on m_ready.
module circular_array_list
    import cal_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_cmd,
    input  logic [5:0]               s_position,
    input  logic signed [DATA_W-1:0] s_item_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_read_data,
    output logic [1:0]               m_status,
    output logic [CNT_W-1:0]         m_count
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_GET    = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        cmd_reg;
    logic [PTR_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;
    logic [PTR_W-1:0]  src_reg, src_next;
    logic [PTR_W-1:0]  dst_reg, dst_next;
    logic [PTR_W-1:0]  moves_reg, moves_next;
    logic              down_reg, down_next;
    logic [DATA_W-1:0] res_data_reg, res_data_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_read_data_reg;
    logic [1:0]        m_status_reg;
    logic [CNT_W-1:0]  m_count_reg;

    mem_req_t          req;
    logic [DATA_W-1:0] rd_data;
    logic [CNT_W-1:0]  pos_ext;
    logic              in_range;
    logic              full;
    logic [CNT_W-1:0]  tail_moves;
    logic              resp_load;

    cal_store u_store (
        .aclk    (aclk),
        .head    (head_reg),
        .req     (req),
        .rd_data (rd_data)
    );

    assign pos_ext    = {{(CNT_W-PTR_W){1'b0}}, pos_reg};
    assign in_range   = pos_ext < count_reg;
    assign full       = count_reg == CNT_W'(DEPTH);
    assign tail_moves = count_reg - CNT_W'(1) - pos_ext;
    assign resp_load  = (state_reg == S_RESP) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        moves_next      = moves_reg;
        down_next       = down_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        req             = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                res_data_next   = '0;
                res_status_next = ST_OK;
                state_next      = S_RESP;
                unique case (cmd_reg)
                    CMD_GET: begin
                        if (in_range) begin
                            req.rd_en  = 1'b1;
                            req.rd_idx = pos_reg;
                            state_next = S_GET;
                        end else begin
                            res_status_next = ST_RANGE;
                        end
                    end
                    CMD_PREPEND, CMD_APPEND: begin
                        if (full) begin
                            res_status_next = ST_FULL;
                        end else begin
                            req.wr_en   = 1'b1;
                            req.wr_data = val_reg;
                            count_next  = count_reg + CNT_W'(1);
                            if (cmd_reg == CMD_PREPEND) begin
                                // logical index minus one is the slot before head
                                req.wr_idx = '1;
                                head_next  = head_reg - PTR_W'(1);
                            end else begin
                                req.wr_idx = count_reg[PTR_W-1:0];
                            end
                        end
                    end
                    CMD_REMOVE: begin
                        if (!in_range) begin
                            res_status_next = ST_RANGE;
                        end else if (pos_ext > (count_reg >> 1)) begin
                            // tail side moves down
                            count_next = count_reg - CNT_W'(1);
                            if (tail_moves != '0) begin
                                down_next   = 1'b1;
                                moves_next  = tail_moves[PTR_W-1:0];
                                req.rd_en   = 1'b1;
                                req.rd_idx  = pos_reg + PTR_W'(1);
                                src_next    = pos_reg + PTR_W'(2);
                                dst_next    = pos_reg;
                                count_next  = count_reg;
                                state_next  = S_SHIFT;
                            end
                        end else begin
                            // head side moves up, element 0 included
                            if (pos_reg != '0) begin
                                down_next  = 1'b0;
                                moves_next = pos_reg;
                                req.rd_en  = 1'b1;
                                req.rd_idx = pos_reg - PTR_W'(1);
                                src_next   = pos_reg - PTR_W'(2);
                                dst_next   = pos_reg;
                                state_next = S_SHIFT;
                            end else begin
                                head_next  = head_reg + PTR_W'(1);
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_GET: begin
                res_data_next = rd_data;
                state_next    = S_RESP;
            end
            S_SHIFT: begin
                // write the element read last cycle, read the next one while moves remain
                req.wr_en   = 1'b1;
                req.wr_idx  = dst_reg;
                req.wr_data = rd_data;
                moves_next  = moves_reg - PTR_W'(1);
                if (moves_reg != PTR_W'(1)) begin
                    req.rd_en  = 1'b1;
                    req.rd_idx = src_reg;
                    if (down_reg) begin
                        src_next = src_reg + PTR_W'(1);
                        dst_next = dst_reg + PTR_W'(1);
                    end else begin
                        src_next = src_reg - PTR_W'(1);
                        dst_next = dst_reg - PTR_W'(1);
                    end
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    if (!down_reg) begin
                        head_next = head_reg + PTR_W'(1);
                    end
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (resp_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (resp_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_valid) begin
            cmd_reg <= s_cmd;
            pos_reg <= s_position;
            val_reg <= s_item_value;
        end
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        moves_reg      <= moves_next;
        down_reg       <= down_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        if (resp_load) begin
            m_read_data_reg <= res_data_reg;
            m_status_reg    <= res_status_reg;
            m_count_reg     <= count_reg;
        end
    end

    assign s_ready     = state_reg == S_IDLE;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_status    = m_status_reg;
    assign m_count     = m_count_reg;

endmodule

// File: src/cal_store.sv
`timescale 1ns / 1ps

module cal_store
    import cal_pkg::*;
(
    input  logic              aclk,
    input  logic [PTR_W-1:0]  head,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  wr_slot;
    logic [PTR_W-1:0]  rd_slot;

    // ring wrap comes from the pointer width
    assign wr_slot = head + req.wr_idx;
    assign rd_slot = head + req.rd_idx;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wr_slot] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[rd_slot];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: test/circular_array_list_tb.sv
`timescale 1ns / 1ps

module circular_array_list_tb;
    import cal_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
    } list_result_t;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    class list_scoreboard;
        logic [DATA_W-1:0] store [DEPTH];
        int unsigned       head;
        int unsigned       count;
        list_result_t      want_q [$];
        int                errors;

        function new();
            for (int i = 0; i < DEPTH; i++) store[i] = '0;
            head   = 0;
            count  = 0;
            errors = 0;
        endfunction

        function int unsigned slot(int unsigned logical);
            return (head + logical) % DEPTH;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        // advance the list model by one accepted item and queue what it should answer
        function void note_command(logic [1:0] cmd, logic [5:0] pos, logic [DATA_W-1:0] val);
            list_result_t r;
            int unsigned  p;
            p = 32'(pos);
            r.data   = '0;
            r.status = ST_OK;
            case (cmd)
                CMD_GET: begin
                    if (p < count) r.data = store[slot(p)];
                    else r.status = ST_RANGE;
                end
                CMD_PREPEND: begin
                    if (count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        head = (head + DEPTH - 1) % DEPTH;
                        store[head] = val;
                        count++;
                    end
                end
                CMD_APPEND: begin
                    if (count >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        store[slot(count)] = val;
                        count++;
                    end
                end
                default: begin
                    if (p >= count) begin
                        r.status = ST_RANGE;
                    end else begin
                        if (p > count / 2) begin
                            // close the gap from the tail side
                            for (int unsigned i = p; i + 1 < count; i++)
                                store[slot(i)] = store[slot(i + 1)];
                        end else begin
                            // move the head side up, element 0 included
                            for (int unsigned i = p; i > 0; i--)
                                store[slot(i)] = store[slot(i - 1)];
                            head = slot(1);
                        end
                        count--;
                    end
                end
            endcase
            r.count = count[CNT_W-1:0];
            want_q.push_back(r);
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(input logic [DATA_W-1:0] data, input logic [1:0] st,
                          input logic [CNT_W-1:0] cnt);
            list_result_t w;
            if (want_q.size() == 0) begin
                report($sformatf("unexpected result data %h status %0d count %0d",
                                 data, st, cnt));
            end else begin
                w = want_q.pop_front();
                if (data !== w.data)
                    report($sformatf("read_data got %h want %h", data, w.data));
                if (st !== w.status)
                    report($sformatf("status got %0d want %0d", st, w.status));
                if (cnt !== w.count)
                    report($sformatf("count got %0d want %0d", cnt, w.count));
            end
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_cmd;
    logic [5:0]               s_position;
    logic signed [DATA_W-1:0] s_item_value;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_read_data;
    logic [1:0]               m_status;
    logic [CNT_W-1:0]         m_count;

    list_scoreboard sb;
    bit             no_idle;

    circular_array_list dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_position   (s_position),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_status     (m_status),
        .m_count      (m_count)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // called at a rising edge, returns at the edge where the item was taken
    task send_item(input logic [1:0] cmd, input logic [5:0] pos, input logic [DATA_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_position   <= pos;
        s_item_value <= val;
        do @(negedge aclk); while (s_ready !== 1'b1);
        @(posedge aclk);
        sb.note_command(cmd, pos, val);
    endtask

    function logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        phase_t      phase;
        int          n;
        int          plen;
        int          r;
        logic [1:0]  cmd;
        logic [5:0]  pos;
        sb = new();
        no_idle      = 1'b0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_cmd        <= CMD_GET;
        s_position   <= '0;
        s_item_value <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list, value extremes, both removal sides, head wrap
        send_item(CMD_GET,     6'd0,  32'h0);
        send_item(CMD_GET,     6'd63, 32'h0);
        send_item(CMD_REMOVE,  6'd0,  32'h0);
        send_item(CMD_APPEND,  6'd0,  32'h7fff_ffff);
        send_item(CMD_APPEND,  6'd63, 32'h8000_0000);
        send_item(CMD_PREPEND, 6'd0,  32'hffff_ffff);
        send_item(CMD_PREPEND, 6'd63, 32'h0000_0000);
        send_item(CMD_APPEND,  6'd0,  32'h5a5a_5a5a);
        for (int i = 0; i < 5; i++) send_item(CMD_GET, i[5:0], $urandom);
        send_item(CMD_GET,     6'd5,  32'h0);
        send_item(CMD_REMOVE,  6'd4,  32'h0);
        send_item(CMD_REMOVE,  6'd0,  32'h0);
        send_item(CMD_REMOVE,  6'd2,  32'h0);
        send_item(CMD_REMOVE,  6'd1,  32'h0);
        send_item(CMD_GET,     6'd0,  32'h0);
        send_item(CMD_REMOVE,  6'd0,  32'h0);
        send_item(CMD_PREPEND, 6'd0,  32'ha5a5_a5a5);
        send_item(CMD_GET,     6'd0,  32'h0);
        send_item(CMD_REMOVE,  6'd63, 32'h0);

        n = 0;
        while (n < 1200) begin
            case ($urandom_range(0, 2))
                0:       phase = PH_FILL;
                1:       phase = PH_DRAIN;
                default: phase = PH_MIXED;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            plen = $urandom_range(30, 80);
            for (int k = 0; k < plen; k++) begin
                r = $urandom_range(0, 99);
                case (phase)
                    PH_FILL:  cmd = (r < 45) ? CMD_APPEND : (r < 90) ? CMD_PREPEND :
                                    (r < 95) ? CMD_GET : CMD_REMOVE;
                    PH_DRAIN: cmd = (r < 75) ? CMD_REMOVE : (r < 90) ? CMD_GET :
                                    (r < 95) ? CMD_APPEND : CMD_PREPEND;
                    default:  cmd = r[1:0];
                endcase
                // mostly valid indexes, some anywhere in the field
                if (sb.count > 0 && $urandom_range(0, 99) < 85)
                    pos = 6'($urandom_range(0, sb.count - 1));
                else
                    pos = 6'($urandom_range(0, 63));
                send_item(cmd, pos, pick_value());
                n++;
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // result side: random stalls plus one long hold-off to back the block up
    initial begin
        int                gap;
        int                results_seen;
        bit                held;
        logic [DATA_W-1:0] got_data;
        logic [1:0]        got_status;
        logic [CNT_W-1:0]  got_count;
        results_seen = 0;
        held         = 1'b0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held && results_seen == 150) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (m_valid !== 1'b1);
            got_data   = m_read_data;
            got_status = m_status;
            got_count  = m_count;
            @(posedge aclk);
            sb.check_result(got_data, got_status, got_count);
            results_seen++;
        end
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
